// ===== hw/rtl/keps_face_flux_unit_assert.svh =====
// Assertion macros for the face flux unit.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef KEPS_FACE_FLUX_UNIT_ASSERT_SVH
`define KEPS_FACE_FLUX_UNIT_ASSERT_SVH
`ifndef SYNTH
`define KEPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keps: check failed");
`define KEPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keps: check failed");
`else
`define KEPS_ASSERT_IMP(lbl, ante, cons)
`define KEPS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/keps_pkg.sv =====
// Shared types, constants, stage timing and saturation helpers of the face flux unit.
// No dependencies.
package keps_pkg;

  localparam int FRAC_BITS = 32;
  localparam int WORD_W    = 64;
  localparam int HALF_W    = WORD_W / 2;
  localparam int DIV_BITS  = 2;
  localparam int DIV_STG   = WORD_W / DIV_BITS;
  localparam int MUL_LAT   = 3;
  localparam int DIV_LAT   = DIV_STG + 2;
  localparam int T_BETA    = DIV_LAT + 1;
  localparam int T_C       = 2 * DIV_LAT + 1 + MUL_LAT;
  localparam int T_E       = T_C + 1;
  localparam int T_Z       = T_E + 2 * MUL_LAT + 1;
  localparam int CFG_IDX_W = 3;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [WORD_W-2:0] uval_t;

  localparam logic [CFG_IDX_W-1:0] CFG_GAS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CSX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CSY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CSZ  = 3'd4;

  localparam uval_t GAS_RST  = 63'd1232655417344;
  localparam uval_t HEAT_RST = 63'd6012954214;
  localparam uval_t CELL_RST = 63'd4294967296;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_ZALT = 2'd3;
  localparam logic [1:0] AXIS_CODE [3] = '{AXIS_X, AXIS_Y, AXIS_Z};

  localparam word_t SMAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t SMIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam uval_t ONE_Q = uval_t'(1) << FRAC_BITS;
  localparam logic [2*WORD_W-1:0] RECIP_NUM = (2*WORD_W)'(1) << (2 * FRAC_BITS);

  typedef struct packed {
    uval_t       rho;
    word_t [2:0] vel;
    logic  [1:0] axis;
  } ctx_t;

  function automatic logic signed [67:0] sx(word_t v);
    return {{4{v[WORD_W-1]}}, v};
  endfunction

  function automatic word_t sat_wide(logic signed [67:0] v);
    if (v[67:63] == '0 || v[67:63] == '1) begin
      return v[63:0];
    end
    return v[67] ? SMIN : SMAX;
  endfunction

endpackage

// ===== hw/rtl/keps_mul.sv =====
// Pipelined signed Q-format multiplier: partial products, sum, shift and saturate.
// Depends on keps_pkg.
module keps_mul (
  input  logic           clk,
  input  logic           en,
  input  keps_pkg::word_t a,
  input  keps_pkg::word_t b,
  output keps_pkg::word_t q
);
  import keps_pkg::*;

  logic signed [WORD_W-1:0]  p11_r;
  logic signed [WORD_W:0]    p10_r;
  logic signed [WORD_W:0]    p01_r;
  logic        [WORD_W-1:0]  p00_r;
  logic signed [2*WORD_W-1:0] prod_r;
  logic signed [2*WORD_W-1:0] prod_nxt;
  word_t                     q_r;
  word_t                     q_nxt;

  always_comb begin
    prod_nxt = $signed({p11_r, {WORD_W{1'b0}}})
             + ($signed({{(WORD_W-1){p10_r[WORD_W]}}, p10_r}) <<< HALF_W)
             + ($signed({{(WORD_W-1){p01_r[WORD_W]}}, p01_r}) <<< HALF_W)
             + $signed({{WORD_W{1'b0}}, p00_r});
  end

  always_comb begin
    if (prod_r[2*WORD_W-1:FRAC_BITS+WORD_W-1] == '0 ||
        prod_r[2*WORD_W-1:FRAC_BITS+WORD_W-1] == '1) begin
      q_nxt = prod_r[FRAC_BITS+WORD_W-1:FRAC_BITS];
    end else begin
      q_nxt = prod_r[2*WORD_W-1] ? SMIN : SMAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p11_r  <= $signed(a[WORD_W-1:HALF_W]) * $signed(b[WORD_W-1:HALF_W]);
      p10_r  <= $signed(a[WORD_W-1:HALF_W]) * $signed({1'b0, b[HALF_W-1:0]});
      p01_r  <= $signed({1'b0, a[HALF_W-1:0]}) * $signed(b[WORD_W-1:HALF_W]);
      p00_r  <= a[HALF_W-1:0] * b[HALF_W-1:0];
      prod_r <= prod_nxt;
      q_r    <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ===== hw/rtl/keps_div.sv =====
// Pipelined restoring divider: 128-bit numerator by 64-bit divisor, saturated quotient.
// Depends on keps_pkg.
module keps_div (
  input  logic           clk,
  input  logic           en,
  input  keps_pkg::word_t num_hi,
  input  keps_pkg::word_t num_lo,
  input  keps_pkg::word_t den,
  output keps_pkg::word_t q
);
  import keps_pkg::*;

  word_t r_r   [DIV_STG+1];
  word_t s_r   [DIV_STG+1];
  word_t d_r   [DIV_STG+1];
  logic  ov_r  [DIV_STG+1];
  word_t r_nxt [DIV_STG+1];
  word_t s_nxt [DIV_STG+1];
  word_t q_r;

  always_comb begin
    logic [WORD_W:0] t;
    word_t           rr;
    word_t           ss;
    r_nxt[0] = num_hi;
    s_nxt[0] = num_lo;
    for (int k = 1; k <= DIV_STG; k++) begin
      rr = r_r[k-1];
      ss = s_r[k-1];
      for (int j = 0; j < DIV_BITS; j++) begin
        t  = {rr, ss[WORD_W-1]};
        ss = {ss[WORD_W-2:0], 1'b0};
        if (t >= {1'b0, d_r[k-1]}) begin
          t     = t - {1'b0, d_r[k-1]};
          ss[0] = 1'b1;
        end
        rr = t[WORD_W-1:0];
      end
      r_nxt[k] = rr;
      s_nxt[k] = ss;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]  <= r_nxt[0];
      s_r[0]  <= s_nxt[0];
      d_r[0]  <= den;
      ov_r[0] <= (den == '0) || (num_hi >= den);
      for (int k = 1; k <= DIV_STG; k++) begin
        r_r[k]  <= r_nxt[k];
        s_r[k]  <= s_nxt[k];
        d_r[k]  <= d_r[k-1];
        ov_r[k] <= ov_r[k-1];
      end
      q_r <= (ov_r[DIV_STG] || s_r[DIV_STG][WORD_W-1]) ? SMAX : s_r[DIV_STG];
    end
  end

  assign q = q_r;

endmodule

// ===== hw/rtl/keps_face_flux_unit.sv =====
// Top level of the face flux unit: configuration registers, stage timing and flux assembly.
// Depends on keps_pkg, keps_mul, keps_div and keps_face_flux_unit_assert.svh.
//
// Computes the kinetic-energy and entropy preserving central Euler flux on one face
// from the left and right cell states, in signed Q32.32 with saturation. One request
// is taken every clock cycle while the output side does not stall. The latency is set
// by the chain of two dividers (the mean inverse temperature, then the reciprocal
// energy term) with the multipliers around them. A stall on the output while out_valid
// is high freezes the whole pipeline and holds off new requests.
// Configuration is taken at any time through cfg_valid and cfg_ready.
`include "keps_face_flux_unit_assert.svh"
module keps_face_flux_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  keps_pkg::uval_t                    in_left_density,
  input  keps_pkg::uval_t                    in_left_pressure,
  input  logic signed [63:0]                 in_left_vel_x,
  input  logic signed [63:0]                 in_left_vel_y,
  input  logic signed [63:0]                 in_left_vel_z,
  input  keps_pkg::uval_t                    in_right_density,
  input  keps_pkg::uval_t                    in_right_pressure,
  input  logic signed [63:0]                 in_right_vel_x,
  input  logic signed [63:0]                 in_right_vel_y,
  input  logic signed [63:0]                 in_right_vel_z,
  input  logic [1:0]                         in_normal_axis,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [63:0]                 out_mass_flux,
  output logic signed [63:0]                 out_momentum_flux_x,
  output logic signed [63:0]                 out_momentum_flux_y,
  output logic signed [63:0]                 out_momentum_flux_z,
  output logic signed [63:0]                 out_energy_flux,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [keps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  keps_pkg::uval_t                    cfg_data
);
  import keps_pkg::*;

  uval_t gas_r;
  uval_t heat_r;
  uval_t csx_r;
  uval_t csy_r;
  uval_t csz_r;

  logic [T_Z:0] vld_r;
  logic         en;

  ctx_t              ctx_nxt;
  ctx_t              ctx_r [T_E+1];
  logic [1:0]        axis_in;
  logic signed [64:0] vsum [3];
  word_t             lin [3];
  word_t             rin [3];
  uval_t             rl_r;
  uval_t             pl_r;
  uval_t             rr_r;
  uval_t             pr_r;
  word_t             lv_r [3];
  word_t             rv_r [3];

  word_t                     sq_a [6];
  word_t                     sq_q [6];
  logic signed [67:0]        sq_acc;
  word_t                     vel2_nxt;
  word_t                     vl_d_r [T_C-MUL_LAT];

  logic [2*WORD_W-1:0] nl;
  logic [2*WORD_W-1:0] nr;
  logic [2*WORD_W-1:0] npm;
  word_t               ql;
  word_t               qr;
  uval_t               beta_r;
  uval_t               beta_nxt;

  word_t       velax;
  word_t       mass_q;
  word_t [2:0] mp_q;
  word_t [2:0] mp_d_r [T_C-2*MUL_LAT];
  word_t       mass_d_r [T_C-MUL_LAT];

  word_t area_a;
  word_t area_b;
  word_t area_q;
  word_t area_d_r [T_E+1];

  word_t pm_q;
  word_t pm_d_r [MUL_LAT];
  word_t hrm1;
  word_t den_q;
  word_t rcp_q;

  logic signed [64:0] diff;
  word_t              coef_nxt;
  word_t [2:0]        mom_nxt;
  word_t              coef_r;
  word_t [2:0]        mom_r;
  word_t              mass_e_r;
  word_t [3:0]        flux_e;

  word_t       ce_q;
  word_t [2:0] me_q;
  word_t [3:0] fa_q;
  word_t [3:0] fa_d_r [MUL_LAT+1];
  word_t       eng_r;
  word_t       eng_nxt;
  word_t       eng_q;

  assign cfg_ready = 1'b1;
  assign en        = !(vld_r[T_Z] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[T_Z];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gas_r  <= GAS_RST;
      heat_r <= HEAT_RST;
      csx_r  <= CELL_RST;
      csy_r  <= CELL_RST;
      csz_r  <= CELL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GAS:  gas_r  <= cfg_data;
        CFG_HEAT: heat_r <= cfg_data;
        CFG_CSX:  csx_r  <= cfg_data;
        CFG_CSY:  csy_r  <= cfg_data;
        CFG_CSZ:  csz_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[T_Z-1:0], in_valid};
    end
  end

  // entry stage: normalise axis, form mean density and mean velocity
  always_comb begin
    lin[0]  = in_left_vel_x;
    lin[1]  = in_left_vel_y;
    lin[2]  = in_left_vel_z;
    rin[0]  = in_right_vel_x;
    rin[1]  = in_right_vel_y;
    rin[2]  = in_right_vel_z;
    axis_in = (in_normal_axis == AXIS_ZALT) ? AXIS_Z : in_normal_axis;
    ctx_nxt.rho  = uval_t'(({1'b0, in_left_density} + {1'b0, in_right_density}) >> 1);
    ctx_nxt.axis = axis_in;
    for (int i = 0; i < 3; i++) begin
      vsum[i] = $signed({lin[i][WORD_W-1], lin[i]}) + $signed({rin[i][WORD_W-1], rin[i]});
      ctx_nxt.vel[i] = vsum[i][WORD_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[0] <= ctx_nxt;
      for (int k = 1; k <= T_E; k++) begin
        ctx_r[k] <= ctx_r[k-1];
      end
      rl_r <= in_left_density;
      pl_r <= in_left_pressure;
      rr_r <= in_right_density;
      pr_r <= in_right_pressure;
      for (int i = 0; i < 3; i++) begin
        lv_r[i] <= lin[i];
        rv_r[i] <= rin[i];
      end
    end
  end

  // squared speeds
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_a[i]   = lv_r[i];
      sq_a[3+i] = rv_r[i];
    end
  end

  for (genvar i = 0; i < 6; i++) begin : g_sq
    keps_mul u_mul (.clk(clk), .en(en), .a(sq_a[i]), .b(sq_a[i]), .q(sq_q[i]));
  end

  always_comb begin
    sq_acc = '0;
    for (int i = 0; i < 6; i++) begin
      sq_acc = sq_acc + sx(sq_q[i]);
    end
    vel2_nxt = sat_wide(sq_acc >>> 1);
  end

  // mean inverse temperature
  assign nl = {65'd0, rl_r} << FRAC_BITS;
  assign nr = {65'd0, rr_r} << FRAC_BITS;

  keps_div u_div_l (
    .clk(clk), .en(en), .num_hi(nl[2*WORD_W-1:WORD_W]), .num_lo(nl[WORD_W-1:0]),
    .den({pl_r, 1'b0}), .q(ql)
  );

  keps_div u_div_r (
    .clk(clk), .en(en), .num_hi(nr[2*WORD_W-1:WORD_W]), .num_lo(nr[WORD_W-1:0]),
    .den({pr_r, 1'b0}), .q(qr)
  );

  assign beta_nxt = uval_t'(({1'b0, ql} + {1'b0, qr}) >> 1);

  // mass flux and its products with the mean velocity
  always_comb begin
    unique case (ctx_r[0].axis)
      AXIS_X:  velax = ctx_r[0].vel[0];
      AXIS_Y:  velax = ctx_r[0].vel[1];
      default: velax = ctx_r[0].vel[2];
    endcase
  end

  keps_mul u_mass (
    .clk(clk), .en(en), .a({1'b0, ctx_r[0].rho}), .b(velax), .q(mass_q)
  );

  for (genvar i = 0; i < 3; i++) begin : g_mv
    keps_mul u_mul (
      .clk(clk), .en(en), .a(mass_q), .b(ctx_r[MUL_LAT].vel[i]), .q(mp_q[i])
    );
  end

  // face area across the normal
  always_comb begin
    unique case (ctx_r[0].axis)
      AXIS_X: begin
        area_a = {1'b0, csy_r};
        area_b = {1'b0, csz_r};
      end
      AXIS_Y: begin
        area_a = {1'b0, csx_r};
        area_b = {1'b0, csz_r};
      end
      default: begin
        area_a = {1'b0, csx_r};
        area_b = {1'b0, csy_r};
      end
    endcase
  end

  keps_mul u_area (.clk(clk), .en(en), .a(area_a), .b(area_b), .q(area_q));

  // face pressure and reciprocal energy term
  assign npm = {65'd0, ctx_r[T_BETA].rho} << FRAC_BITS;

  keps_div u_div_pm (
    .clk(clk), .en(en), .num_hi(npm[2*WORD_W-1:WORD_W]), .num_lo(npm[WORD_W-1:0]),
    .den({beta_r, 1'b0}), .q(pm_q)
  );

  assign hrm1 = (heat_r > ONE_Q) ? {1'b0, heat_r - ONE_Q} : '0;

  keps_mul u_denom (.clk(clk), .en(en), .a(hrm1), .b({1'b0, beta_r}), .q(den_q));

  keps_div u_div_rcp (
    .clk(clk), .en(en), .num_hi(RECIP_NUM[2*WORD_W-1:WORD_W]),
    .num_lo(RECIP_NUM[WORD_W-1:0]), .den(den_q), .q(rcp_q)
  );

  // join stage: energy coefficient and momentum flux
  always_comb begin
    diff = $signed({1'b0, rcp_q})
         - $signed({vl_d_r[T_C-MUL_LAT-1][WORD_W-1], vl_d_r[T_C-MUL_LAT-1]});
    coef_nxt = diff[WORD_W:1];
    for (int i = 0; i < 3; i++) begin
      mom_nxt[i] = sat_wide(sx(mp_d_r[T_C-2*MUL_LAT-1][i]) +
                            ((ctx_r[T_C].axis == AXIS_CODE[i]) ?
                             sx(pm_d_r[MUL_LAT-1]) : 68'sd0));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      beta_r    <= beta_nxt;
      vl_d_r[0] <= vel2_nxt;
      for (int k = 1; k < T_C-MUL_LAT; k++) begin
        vl_d_r[k] <= vl_d_r[k-1];
      end
      mp_d_r[0] <= mp_q;
      for (int k = 1; k < T_C-2*MUL_LAT; k++) begin
        mp_d_r[k] <= mp_d_r[k-1];
      end
      mass_d_r[0] <= mass_q;
      for (int k = 1; k < T_C-MUL_LAT; k++) begin
        mass_d_r[k] <= mass_d_r[k-1];
      end
      area_d_r[0] <= area_q;
      for (int k = 1; k <= T_E; k++) begin
        area_d_r[k] <= area_d_r[k-1];
      end
      pm_d_r[0] <= pm_q;
      for (int k = 1; k < MUL_LAT; k++) begin
        pm_d_r[k] <= pm_d_r[k-1];
      end
      coef_r   <= coef_nxt;
      mom_r    <= mom_nxt;
      mass_e_r <= mass_d_r[T_C-MUL_LAT-1];
      eng_r    <= eng_nxt;
      fa_d_r[0] <= fa_q;
      for (int k = 1; k <= MUL_LAT; k++) begin
        fa_d_r[k] <= fa_d_r[k-1];
      end
    end
  end

  // energy flux and area scaling
  assign flux_e = {mom_r[2], mom_r[1], mom_r[0], mass_e_r};

  keps_mul u_ce (.clk(clk), .en(en), .a(coef_r), .b(mass_e_r), .q(ce_q));

  for (genvar i = 0; i < 3; i++) begin : g_me
    keps_mul u_mul (
      .clk(clk), .en(en), .a(mom_r[i]), .b(ctx_r[T_E].vel[i]), .q(me_q[i])
    );
  end

  for (genvar i = 0; i < 4; i++) begin : g_fa
    keps_mul u_mul (
      .clk(clk), .en(en), .a(flux_e[i]), .b(area_d_r[T_E-MUL_LAT-1]), .q(fa_q[i])
    );
  end

  assign eng_nxt = sat_wide(sx(ce_q) + sx(me_q[0]) + sx(me_q[1]) + sx(me_q[2]));

  keps_mul u_eng (.clk(clk), .en(en), .a(eng_r), .b(area_d_r[T_E]), .q(eng_q));

  assign out_mass_flux       = fa_d_r[MUL_LAT][0];
  assign out_momentum_flux_x = fa_d_r[MUL_LAT][1];
  assign out_momentum_flux_y = fa_d_r[MUL_LAT][2];
  assign out_momentum_flux_z = fa_d_r[MUL_LAT][3];
  assign out_energy_flux     = eng_q;

  `KEPS_ASSERT_NXT(a_accept_enters, in_valid && !in_stall, vld_r[0])
  `KEPS_ASSERT_NXT(a_stall_holds, vld_r[T_Z] && out_stall, $stable(vld_r))
  `KEPS_ASSERT_NXT(a_cfg_gas, cfg_valid && cfg_ready && (cfg_index == CFG_GAS), gas_r == $past(cfg_data))

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for keps_face_flux_unit: random and directed face states,
// checked against a bit-exact Q32.32 flux predictor kept in a small scoreboard class.
// Depends on keps_pkg and the RTL of the face flux unit.
module tb;
  import keps_pkg::*;

  localparam int  LAT_WAIT   = 120;
  localparam int  IDLE_LIMIT = 6000;
  localparam int  HOLD_LEN   = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef struct {
    uval_t             rho_l, p_l, rho_r, p_r;
    logic signed [63:0] vl [3];
    logic signed [63:0] vr [3];
    logic [1:0]        axis;
  } face_req_t;

  typedef struct {
    word_t f [5];
  } face_flux_t;

  class flux_board;
    uval_t      gas, heat, csize [3];
    face_flux_t pending [$];
    int         errors;

    function void reset_regs();
      gas = GAS_RST;
      heat = HEAT_RST;
      foreach (csize[i]) csize[i] = CELL_RST;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, uval_t v);
      case (idx)
        CFG_GAS:  gas = v;
        CFG_HEAT: heat = v;
        CFG_CSX:  csize[0] = v;
        CFG_CSY:  csize[1] = v;
        CFG_CSZ:  csize[2] = v;
        default: ;
      endcase
    endfunction

    function logic signed [127:0] wx(word_t w);
      return {{64{w[63]}}, w};
    endfunction

    function word_t clip(logic signed [127:0] v);
      if (v[127:63] == '0 || v[127:63] == '1) return v[63:0];
      return v[127] ? SMIN : SMAX;
    endfunction

    function word_t qmul(word_t a, word_t b);
      logic signed [127:0] p;
      p = wx(a) * wx(b);
      return clip(p >>> FRAC_BITS);
    endfunction

    function word_t qdiv(logic [127:0] n, logic [63:0] d);
      logic [127:0] q;
      if (d == 0) return SMAX;
      q = n / d;
      if (q > 128'(SMAX)) return SMAX;
      return q[63:0];
    endfunction

    function word_t half_quot(word_t num, word_t den);
      return qdiv(128'(num) << FRAC_BITS, den << 1);
    endfunction

    function face_flux_t face_flux(face_req_t r);
      face_flux_t          res;
      word_t               rho, beta, pm, vel2, mass, denom, recip, coef, area;
      word_t               vel [3], mom [3];
      logic signed [127:0] acc;
      int                  ax;
      ax = (r.axis == AXIS_ZALT) ? 2 : int'(r.axis);
      rho = ({1'b0, r.rho_l} + {1'b0, r.rho_r}) >> 1;
      beta = (half_quot({1'b0, r.rho_l}, {1'b0, r.p_l})
              + half_quot({1'b0, r.rho_r}, {1'b0, r.p_r})) >> 1;
      pm = half_quot(rho, beta);
      acc = '0;
      for (int i = 0; i < 3; i++) begin
        vel[i] = clip((wx(r.vl[i]) + wx(r.vr[i])) >>> 1);
        acc += wx(qmul(r.vl[i], r.vl[i])) + wx(qmul(r.vr[i], r.vr[i]));
      end
      vel2 = clip(acc >>> 1);
      mass = qmul(rho, vel[ax]);
      for (int i = 0; i < 3; i++)
        mom[i] = clip(wx(qmul(mass, vel[i])) + ((i == ax) ? wx(pm) : '0));
      denom = (heat > ONE_Q) ? qmul({1'b0, heat - ONE_Q}, beta) : '0;
      recip = qdiv(128'(1) << (2 * FRAC_BITS), denom);
      coef = clip((wx(recip) - wx(vel2)) >>> 1);
      acc = wx(qmul(coef, mass));
      for (int i = 0; i < 3; i++) acc += wx(qmul(mom[i], vel[i]));
      if (ax == 0) area = qmul({1'b0, csize[1]}, {1'b0, csize[2]});
      else if (ax == 1) area = qmul({1'b0, csize[0]}, {1'b0, csize[2]});
      else area = qmul({1'b0, csize[0]}, {1'b0, csize[1]});
      res.f[0] = qmul(mass, area);
      for (int i = 0; i < 3; i++) res.f[i+1] = qmul(mom[i], area);
      res.f[4] = qmul(clip(acc), area);
      return res;
    endfunction

    function void note_request(face_req_t r);
      pending.push_back(face_flux(r));
    endfunction

    function void check_flux(face_flux_t got);
      face_flux_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result at %0t", $realtime);
        return;
      end
      want = pending.pop_front();
      for (int i = 0; i < 5; i++)
        if (got.f[i] !== want.f[i]) begin
          errors++;
          if (errors <= 10)
            $display("flux %0d mismatch at %0t: expected %h actual %h",
                     i, $realtime, want.f[i], got.f[i]);
        end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_stall;
  uval_t in_left_density = 0, in_left_pressure = 0, in_right_density = 0;
  uval_t in_right_pressure = 0;
  logic signed [63:0] in_left_vel_x = 0, in_left_vel_y = 0, in_left_vel_z = 0;
  logic signed [63:0] in_right_vel_x = 0, in_right_vel_y = 0, in_right_vel_z = 0;
  logic [1:0] in_normal_axis = 0;
  logic out_valid, out_stall = 0;
  logic signed [63:0] out_mass_flux, out_momentum_flux_x, out_momentum_flux_y;
  logic signed [63:0] out_momentum_flux_z, out_energy_flux;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  uval_t cfg_data = 0;

  flux_board board = new();
  bit quiet = 0;
  bit long_hold = 0;
  int idle_cycles = 0;

  keps_face_flux_unit u_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    face_req_t  r;
    face_flux_t o;
    if (rst_n && in_valid && !in_stall) begin
      r.rho_l = in_left_density;
      r.p_l = in_left_pressure;
      r.rho_r = in_right_density;
      r.p_r = in_right_pressure;
      r.vl = '{in_left_vel_x, in_left_vel_y, in_left_vel_z};
      r.vr = '{in_right_vel_x, in_right_vel_y, in_right_vel_z};
      r.axis = in_normal_axis;
      board.note_request(r);
    end
    if (rst_n && out_valid && !out_stall) begin
      o.f = '{out_mass_flux, out_momentum_flux_x, out_momentum_flux_y,
              out_momentum_flux_z, out_energy_flux};
      board.check_flux(o);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else if (rst_n)
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL keps_face_flux_unit");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        long_hold = 0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic uval_t rnd_pos();
    case ($urandom_range(0, 9))
      0:       return uval_t'({$urandom, $urandom});
      1:       return uval_t'($urandom_range(0, 3));
      default: return {27'd0, 4'($urandom_range(0, 15)), 32'($urandom)};
    endcase
  endfunction

  function automatic logic signed [63:0] rnd_vel();
    logic s;
    s = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
    return {{31{s}}, 33'({$urandom_range(0, 1), $urandom})};
  endfunction

  function automatic face_req_t rnd_face();
    face_req_t r;
    r.rho_l = rnd_pos();
    r.p_l = rnd_pos();
    r.rho_r = rnd_pos();
    r.p_r = rnd_pos();
    foreach (r.vl[i]) r.vl[i] = rnd_vel();
    foreach (r.vr[i]) r.vr[i] = rnd_vel();
    r.axis = 2'($urandom_range(0, 3));
    return r;
  endfunction

  task automatic send_face(face_req_t r);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_left_density <= r.rho_l;
    in_left_pressure <= r.p_l;
    in_right_density <= r.rho_r;
    in_right_pressure <= r.p_r;
    in_left_vel_x <= r.vl[0];
    in_left_vel_y <= r.vl[1];
    in_left_vel_z <= r.vl[2];
    in_right_vel_x <= r.vr[0];
    in_right_vel_y <= r.vr[1];
    in_right_vel_z <= r.vr[2];
    in_normal_axis <= r.axis;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LAT_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, uval_t v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic directed_faces();
    face_req_t r;
    uval_t     umax;
    umax = '1;
    for (int k = 0; k < 20; k++) begin
      r = rnd_face();
      r.axis = AXIS_CODE[k % 3];
      case (k)
        0: begin r.rho_l = umax; r.rho_r = umax; r.p_l = umax; r.p_r = umax; end
        1: begin r.p_l = '0; r.p_r = '0; end
        2: begin r.rho_l = '0; r.rho_r = '0; end
        3: begin
          r.rho_l = uval_t'(1); r.p_l = umax; r.rho_r = uval_t'(1); r.p_r = umax;
        end
        4: begin foreach (r.vl[i]) r.vl[i] = SMIN; foreach (r.vr[i]) r.vr[i] = SMIN; end
        5: begin foreach (r.vl[i]) r.vl[i] = SMAX; foreach (r.vr[i]) r.vr[i] = SMAX; end
        6: begin r.vl = '{SMAX, SMIN, '0}; r.vr = '{SMIN, SMAX, '0}; end
        7: r.axis = AXIS_ZALT;
        8: begin r.rho_l = umax; r.rho_r = umax; r.p_l = uval_t'(1); r.p_r = uval_t'(1); end
        9: begin foreach (r.vl[i]) r.vl[i] = '0; foreach (r.vr[i]) r.vr[i] = '0; end
        10: r.axis = AXIS_ZALT;
        default: ;
      endcase
      send_face(r);
    end
  endtask

  initial begin
    uval_t umax;
    umax = '1;
    board.reset_regs();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_faces();
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        1: begin
          write_reg(CFG_GAS, umax);
          write_reg(CFG_HEAT, ONE_Q);
          write_reg(CFG_CSX, uval_t'(1));
          write_reg(CFG_CSY, umax);
          write_reg(CFG_CSZ, ONE_Q << 1);
        end
        2: begin
          write_reg(CFG_GAS, uval_t'(1));
          write_reg(CFG_HEAT, umax);
          write_reg(CFG_CSX, umax);
          write_reg(CFG_CSY, uval_t'(1));
          write_reg(CFG_CSZ, umax);
          write_reg(CFG_SPARE, '0);
        end
        3: begin
          write_reg(CFG_HEAT, uval_t'(1));
          write_reg(CFG_CSX, uval_t'({$urandom, $urandom}));
          write_reg(CFG_CSY, ONE_Q >> 1);
          write_reg(CFG_CSZ, uval_t'(1));
        end
        4: begin
          write_reg(CFG_GAS, uval_t'({$urandom, $urandom}));
          write_reg(CFG_HEAT, ONE_Q + uval_t'(1));
          write_reg(CFG_CSX, ONE_Q);
          write_reg(CFG_CSY, ONE_Q);
          write_reg(CFG_CSZ, ONE_Q);
        end
        5: begin
          write_reg(CFG_HEAT, HEAT_RST);
          quiet = 1;
        end
        default: ;
      endcase
      for (int k = 0; k < 215; k++) begin
        if (ph == 1 && k == 20) long_hold = 1;
        if (ph == 3 && k == 100) drain();
        send_face(rnd_face());
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LAT_WAIT) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("PASS keps_face_flux_unit");
    else
      $display("FAIL keps_face_flux_unit");
    $finish;
  end
endmodule
